// ----- hw/rtl/sefd_pkg.sv -----
// Package for the socket event frame detector.
// Holds the header pattern table, character codes and the default length width.
// No dependencies; the detector module imports it.
package sefd_pkg;

	localparam int LENGTH_BITS_DEFAULT = 16;

	localparam int SHORT_LEN = 12;
	localparam int LONG_LEN  = 19;

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Expected byte at each place of "\r\n+CIPEVENT:SOCKET,". The short header is
	// the first twelve places of the same string.
	function automatic logic [7:0] pattern_byte(input logic [4:0] idx);
		logic [7:0] c;
		unique case (idx)
			5'd0:    c = CHAR_CR;
			5'd1:    c = CHAR_LF;
			5'd2:    c = 8'h2B; // +
			5'd3:    c = 8'h43; // C
			5'd4:    c = 8'h49; // I
			5'd5:    c = 8'h50; // P
			5'd6:    c = 8'h45; // E
			5'd7:    c = 8'h56; // V
			5'd8:    c = 8'h45; // E
			5'd9:    c = 8'h4E; // N
			5'd10:   c = 8'h54; // T
			5'd11:   c = 8'h3A; // :
			5'd12:   c = 8'h53; // S
			5'd13:   c = 8'h4F; // O
			5'd14:   c = 8'h43; // C
			5'd15:   c = 8'h4B; // K
			5'd16:   c = 8'h45; // E
			5'd17:   c = 8'h54; // T
			5'd18:   c = CHAR_COMMA;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	endfunction

endpackage

// ----- hw/rtl/sefd_in_if.sv -----
// Byte request channel of the socket event frame detector.
// Carries one received modem character and its start-of-buffer flag.
// Depends on nothing.
interface sefd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       first;

	modport source(output valid, rx_byte, first, input ready);
	modport sink(input valid, rx_byte, first, output ready);
endinterface

// ----- hw/rtl/sefd_out_if.sv -----
// Result request channel of the socket event frame detector.
// Carries the match and claim flags and the parsed header fields.
// Depends on nothing.
interface sefd_out_if;
	logic        valid;
	logic        ready;
	logic        match;
	logic        claim;
	logic [7:0]  socket_id;
	logic [15:0] payload_length;
	logic        header_parsed;

	modport source(output valid, match, claim, socket_id, payload_length, header_parsed,
		input ready);
	modport sink(input valid, match, claim, socket_id, payload_length, header_parsed,
		output ready);
endinterface

// ----- hw/rtl/socket_event_frame_detector.sv -----
// Socket event frame detector: one byte request in, one result request out per byte.
// A byte is registered on acceptance and its result is formed by one stage of logic into
// an output register, so a byte can be taken every clock cycle while the result is not stalled.
// The only loop is the per-byte parser state (position, header compare, comma count,
// decimal accumulators), which is updated once per processed byte. Uses sefd_pkg, sefd_in_if and
// sefd_out_if.
module socket_event_frame_detector
	import sefd_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	sefd_in_if.sink     data,
	sefd_out_if.source  result
);

	localparam int TotW  = LENGTH_BITS + 2;
	localparam int AccW  = LENGTH_BITS + 4;
	localparam int WideW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       advance;

	// Parser state
	logic [LENGTH_BITS-1:0] pos_q, pos_n;
	logic                   short_eq_q, short_eq_n;
	logic                   long_eq_q, long_eq_n;
	logic                   prefix_q, prefix_n;
	logic                   parsed_q, parsed_n;
	logic [1:0]             comma_q, comma_n;
	logic [7:0]             prev_q;
	logic [7:0]             id_q, id_n;
	logic [LENGTH_BITS-1:0] acc_q, acc_n;
	logic                   bad_q, bad_n;
	logic [TotW-1:0]        tot_q, tot_n;

	// Result register
	logic        res_valid_q;
	logic        match_q, claim_q, parsed_out_q;
	logic [7:0]  id_out_q;
	logic [15:0] plen_out_q;

	logic                   start;
	logic [LENGTH_BITS-1:0] len;
	logic [LENGTH_BITS-1:0] len_m1;
	logic [7:0]             pat;
	logic [3:0]             digit;
	logic [11:0]            id_wide;
	logic [7:0]             id_sat;
	logic [AccW-1:0]        acc_wide;
	logic [LENGTH_BITS-1:0] acc_sat;
	logic [TotW-1:0]        total;
	logic                   match_n, claim_n;
	logic [WideW-1:0]       acc_ext;
	logic [15:0]            plen_n;

	assign advance    = !res_valid_q || result.ready;
	assign data.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.ready) begin
			valid_s1 <= data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data.ready && data.valid) begin
			byte_s1  <= data.rx_byte;
			first_s1 <= data.first;
		end
	end

	assign start  = first_s1 || (pos_q == '0);
	assign len    = (pos_q != '1) ? pos_q + LENGTH_BITS'(1) : pos_q;
	assign len_m1 = len - LENGTH_BITS'(1);
	assign pat    = pattern_byte(len_m1[4:0]);
	assign digit  = byte_s1[3:0];

	// Decimal accumulation: x * 10 as two shifts and an add, then saturate.
	assign id_wide  = (12'(id_q) << 3) + (12'(id_q) << 1) + 12'(digit);
	assign id_sat   = (id_wide > 12'd255) ? 8'hFF : id_wide[7:0];
	assign acc_wide = (AccW'(acc_q) << 3) + (AccW'(acc_q) << 1) + AccW'(digit);
	assign acc_sat  = (acc_wide > AccW'({LENGTH_BITS{1'b1}})) ? '1 : acc_wide[LENGTH_BITS-1:0];

	// position - 1 + length + 2 cannot exceed the total's range, so no clamp is needed.
	assign total = TotW'(len) + TotW'(acc_n) + TotW'(1);

	always_comb begin
		pos_n      = pos_q;
		short_eq_n = short_eq_q;
		long_eq_n  = long_eq_q;
		prefix_n   = prefix_q;
		parsed_n   = parsed_q;
		comma_n    = comma_q;
		id_n       = id_q;
		acc_n      = acc_q;
		bad_n      = bad_q;
		tot_n      = tot_q;
		match_n    = 1'b0;
		claim_n    = 1'b0;
		if (start) begin
			pos_n      = LENGTH_BITS'(1);
			short_eq_n = (byte_s1 == pattern_byte(5'd0));
			long_eq_n  = (byte_s1 == pattern_byte(5'd0));
			prefix_n   = 1'b0;
			parsed_n   = 1'b0;
			comma_n    = 2'd0;
			id_n       = 8'd0;
			acc_n      = '0;
			bad_n      = 1'b0;
			tot_n      = '0;
		end else begin
			pos_n = len;
			if (len <= LENGTH_BITS'(SHORT_LEN) && byte_s1 != pat) begin
				short_eq_n = 1'b0;
			end
			if (len <= LENGTH_BITS'(LONG_LEN) && byte_s1 != pat) begin
				long_eq_n = 1'b0;
			end
			priority if (len < LENGTH_BITS'(SHORT_LEN)) begin
				// Too early to decide.
			end else if (len == LENGTH_BITS'(SHORT_LEN) && short_eq_n) begin
				prefix_n = 1'b1;
			end else if (prefix_q) begin
				claim_n = 1'b1;
				if (!parsed_q) begin
					if (prev_q == CHAR_CR && byte_s1 == CHAR_LF) begin
						match_n = 1'b1;
					end else if (len > LENGTH_BITS'(LONG_LEN) && long_eq_n) begin
						if (byte_s1 == CHAR_COMMA) begin
							// An empty or non-numeric field before the first or second separator fails it.
							if (comma_q < 2'd2 && !is_digit(prev_q)) begin
								bad_n = 1'b1;
							end
							if (comma_q != 2'd3) begin
								comma_n = comma_q + 2'd1;
							end
						end else if (comma_q < 2'd2) begin
							if (!is_digit(byte_s1)) begin
								bad_n = 1'b1;
							end else if (comma_q == 2'd0) begin
								id_n = id_sat;
							end else begin
								acc_n = acc_sat;
							end
						end
						if (comma_n == 2'd3 && !bad_n) begin
							tot_n    = total;
							parsed_n = 1'b1;
						end
					end
				end else begin
					match_n = (TotW'(len) >= tot_q);
				end
			end
		end
	end

	always_comb begin
		acc_ext = WideW'(acc_n);
		plen_n  = (acc_ext > WideW'(16'hFFFF)) ? 16'hFFFF : acc_ext[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			short_eq_q <= 1'b1;
			long_eq_q  <= 1'b1;
			prefix_q   <= 1'b0;
			parsed_q   <= 1'b0;
			comma_q    <= 2'd0;
			prev_q     <= 8'd0;
			id_q       <= 8'd0;
			acc_q      <= '0;
			bad_q      <= 1'b0;
			tot_q      <= '0;
		end else if (valid_s1 && advance) begin
			pos_q      <= pos_n;
			short_eq_q <= short_eq_n;
			long_eq_q  <= long_eq_n;
			prefix_q   <= prefix_n;
			parsed_q   <= parsed_n;
			comma_q    <= comma_n;
			prev_q     <= byte_s1;
			id_q       <= id_n;
			acc_q      <= acc_n;
			bad_q      <= bad_n;
			tot_q      <= tot_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			match_q      <= match_n;
			claim_q      <= claim_n;
			parsed_out_q <= parsed_n;
			id_out_q     <= parsed_n ? id_n : 8'd0;
			plen_out_q   <= parsed_n ? plen_n : 16'd0;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.match          = match_q;
	assign result.claim          = claim_q;
	assign result.socket_id      = id_out_q;
	assign result.payload_length = plen_out_q;
	assign result.header_parsed  = parsed_out_q;

`ifndef ASSERT_OFF
	a_match_claims: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.match |-> result.claim)
		else $error("match raised on a message that is not claimed");

	a_fields_zero_unparsed: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.header_parsed |->
			(result.socket_id == 8'd0) && (result.payload_length == 16'd0))
		else $error("header fields shown before the header was parsed");

	a_parsed_needs_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		parsed_q |-> prefix_q && long_eq_q)
		else $error("header parsed without the event prefix");

	a_third_comma_parses: assert property (@(posedge clk) disable iff (!arst_n)
		(comma_q == 2'd3) && !bad_q |-> parsed_q)
		else $error("third comma with good fields did not finish the parse");

	a_position_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> pos_q != '0)
		else $error("position is zero after a processed byte");
`endif

endmodule
